/* src/ttab_pkg.sv */
// ----------------------------------------------------------------------------
// ttab_pkg
// shared types, codes and port layout of the track table engine
// ----------------------------------------------------------------------------
package ttab_pkg;

  // defaults of the top level parameters
  localparam int TRACKS_DEF      = 16;
  localparam int POINTS_DEF      = 16;
  localparam int ID_WIDTH_DEF    = 16;
  localparam int POINT_WIDTH_DEF = 64;

  // stream layout
  localparam int S_TDATA_W = 96;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 96;
  localparam int M_TUSER_W = 2;

  localparam logic [2:0] MAXEX_RESET = 3'd3;

  typedef logic [2:0] func_t;
  localparam func_t FN_CREATE = 3'd0;
  localparam func_t FN_DELETE = 3'd1;
  localparam func_t FN_PUSH   = 3'd2;
  localparam func_t FN_MERGE  = 3'd3;
  localparam func_t FN_READ   = 3'd4;
  localparam func_t FN_CLEAR  = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_ASSOC  = 2'd0;
  localparam status_t ST_EXTRAP = 2'd1;
  localparam status_t ST_TERM   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_MRG_RD,
    S_MRG_WR,
    S_MRG_END,
    S_RD_REQ,
    S_RD_DATA,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] id;
    status_t     st;
    logic [2:0]  miss;
    logic [4:0]  cnt;
    logic [63:0] pt;
    logic        pv;
    logic        last;
  } res_t;

endpackage

/* src/track_table_engine.sv */
// ----------------------------------------------------------------------------
// track_table_engine
// track table with free slot stack, point rings, merge and read out
// ----------------------------------------------------------------------------
// One command is taken at a time; s_tready is high only while the sequencer
// is idle. create and clear go from idle straight to the execute step. delete,
// push, merge and read out first scan every slot for the addressed id, one
// slot a cycle, then execute. A successful merge copies max_extrapolations
// points, each by one ram read then one ram write through the single point
// ram port pair; a closing step gives the target slot the source id, state
// and miss count and frees the source slot. read out of an empty or missing
// track answers from the execute step; read out of a non-empty track passes
// each stored point through a ram read request, registered ram data and an
// output transfer. The sequencer waits in its output state while the result
// stream stalls. Every command gives one result, read out of a non-empty
// track one result per point, oldest first; the final result carries tlast.
// No clearing pass is needed after reset: point storage is only read where
// it was written.
module track_table_engine
  import ttab_pkg::*;
#(
  parameter int TRACKS      = TRACKS_DEF,
  parameter int POINTS      = POINTS_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF,
  parameter int POINT_WIDTH = POINT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // command stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // addressed id, target id, point data
  input  logic [S_TUSER_W-1:0] s_tuser,  // func, point_associated
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // result_id, track_state, miss_count, point_count, out_point
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [M_TUSER_W-1:0] m_tuser,  // ok, point_valid
  output logic                 m_tlast,
  // max_extrapolations register
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_data
);

  localparam int SW  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int PW  = $clog2(POINTS);
  localparam int FW  = $clog2(POINTS + 1);
  localparam int DW  = $clog2(TRACKS + 1);
  localparam int AW  = $clog2(TRACKS * POINTS);
  localparam int IW  = ID_WIDTH;
  localparam int PTW = POINT_WIDTH;

  // slot table
  logic          slot_used  [TRACKS];
  logic [IW-1:0] slot_tid   [TRACKS];
  status_t       slot_st    [TRACKS];
  logic [2:0]    slot_miss  [TRACKS];
  logic [PW-1:0] ring_head  [TRACKS];
  logic [FW-1:0] ring_fill  [TRACKS];
  logic [SW-1:0] free_stack [TRACKS];
  logic [DW-1:0] free_depth;
  logic [IW-1:0] next_id;
  logic [2:0]    maxex;

  // command registers
  state_t        state, state_next;
  func_t         func_r;
  logic [IW-1:0] id_r, oid_r;
  logic [PTW-1:0] pt_r;
  logic          assoc_r;
  logic [SW-1:0] sc;
  logic [SW-1:0] s_idx, t_idx;
  logic          s_hit, t_hit;
  logic [FW-1:0] cnt;
  logic [PW-1:0] sptr, tptr;
  res_t          res_r;

  // point ram
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [PTW-1:0] ram_wdata, ram_rdata;

  ttab_ram #(.WIDTH(PTW), .DEPTH(TRACKS * POINTS)) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [AW-1:0] pt_addr(input logic [SW-1:0] s, input logic [PW-1:0] p);
    pt_addr = AW'(AW'(s) * AW'(POINTS) + AW'(p));
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(POINTS - 1) : PW'(p - 1'b1);
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(POINTS - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  // input unpacking
  func_t          in_func;
  logic [IW-1:0]  in_id, in_oid;
  logic [PTW-1:0] in_pt;
  logic           in_assoc;

  assign in_func  = s_tuser[2:0];
  assign in_assoc = s_tuser[3];
  assign in_id    = IW'(s_tdata[15:0]);
  assign in_oid   = IW'(s_tdata[31:16]);
  assign in_pt    = PTW'(s_tdata[95:32]);

  // views of the found slots
  logic [PW-1:0] hs;
  logic [FW-1:0] fs, ft;
  status_t       ss;
  logic [2:0]    ms;
  logic          merge_ok;
  logic [PW:0]   rd_sum;
  logic [PW-1:0] rd_start;
  logic          scan_end;

  assign hs = ring_head[s_idx];
  assign fs = ring_fill[s_idx];
  assign ft = ring_fill[t_idx];
  assign ss = slot_st[s_idx];
  assign ms = slot_miss[s_idx];
  assign merge_ok = s_hit && t_hit && (s_idx != t_idx) &&
                    (fs >= FW'(maxex)) && (ft >= FW'(maxex));
  // oldest point sits fill places behind the head
  assign rd_sum   = (PW + 1)'(hs) + (PW + 1)'(POINTS) - (PW + 1)'(fs);
  assign rd_start = (rd_sum >= (PW + 1)'(POINTS)) ? PW'(rd_sum - (PW + 1)'(POINTS))
                                                  : PW'(rd_sum);
  assign scan_end = (sc == SW'(TRACKS - 1));

  // push outcome
  logic [FW-1:0] push_fill;
  logic [2:0]    push_miss;
  status_t       push_st;

  always_comb begin
    push_fill = (fs < FW'(POINTS)) ? FW'(fs + 1'b1) : fs;
    push_miss = ms;
    push_st   = ss;
    if (assoc_r) begin
      if (ms != '0) push_miss = ms - 3'd1;
      push_st = ST_ASSOC;
    end else if (ms < maxex) begin
      push_miss = ms + 3'd1;
      push_st   = ST_EXTRAP;
    end else begin
      push_st = ST_TERM;
    end
  end

  // result of the execute step
  res_t exec_res;

  always_comb begin
    exec_res      = '0;
    exec_res.last = 1'b1;
    case (func_r)
      FN_CREATE: begin
        if (free_depth != '0) begin
          exec_res.ok = 1'b1;
          exec_res.id = 16'(next_id);
        end
      end
      FN_DELETE: begin
        exec_res.id = 16'(id_r);
        exec_res.ok = s_hit;
      end
      FN_PUSH: begin
        exec_res.id = 16'(id_r);
        if (s_hit && ss != ST_TERM) begin
          exec_res.ok   = 1'b1;
          exec_res.st   = push_st;
          exec_res.miss = push_miss;
          exec_res.cnt  = 5'(push_fill);
        end
      end
      FN_MERGE: begin
        exec_res.id = 16'(id_r);
      end
      FN_READ: begin
        exec_res.id = 16'(id_r);
        if (s_hit) begin
          exec_res.ok   = 1'b1;
          exec_res.st   = ss;
          exec_res.miss = ms;
          exec_res.cnt  = 5'(fs);
        end
      end
      FN_CLEAR: begin
        exec_res.ok = 1'b1;
      end
      default: begin
        exec_res.last = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_func inside {FN_DELETE, FN_PUSH, FN_MERGE, FN_READ}) state_next = S_SCAN;
          else state_next = S_EXEC;
        end
      end
      S_SCAN: begin
        if (scan_end) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (func_r == FN_MERGE && merge_ok) begin
          state_next = (maxex == '0) ? S_MRG_END : S_MRG_RD;
        end else if (func_r == FN_READ && s_hit && fs != '0) begin
          state_next = S_RD_REQ;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MRG_RD:  state_next = S_MRG_WR;
      S_MRG_WR: begin
        state_next = (cnt == FW'(1)) ? S_MRG_END : S_MRG_RD;
      end
      S_MRG_END: state_next = S_OUT;
      S_RD_REQ:  state_next = S_RD_DATA;
      S_RD_DATA: state_next = S_OUT;
      S_OUT: begin
        if (m_tready) state_next = res_r.last ? S_IDLE : S_RD_REQ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and ram control
  always_comb begin
    s_tready  = (state == S_IDLE);
    m_tvalid  = (state == S_OUT);
    ram_we    = 1'b0;
    ram_waddr = pt_addr(s_idx, hs);
    ram_wdata = pt_r;
    ram_raddr = pt_addr(s_idx, sptr);
    case (state)
      S_EXEC: begin
        ram_we = (func_r == FN_PUSH) && s_hit;
      end
      S_MRG_RD: begin
        ram_raddr = pt_addr(s_idx, ptr_dec(sptr));
      end
      S_MRG_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pt_addr(t_idx, tptr);
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign m_tdata   = {6'b0, res_r.pt, res_r.cnt, res_r.miss, res_r.st, res_r.id};
  assign m_tuser   = {res_r.pv, res_r.ok};
  assign m_tlast   = res_r.last;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      maxex      <= MAXEX_RESET;
      free_depth <= DW'(TRACKS);
      next_id    <= IW'(1);
      for (int i = 0; i < TRACKS; i++) begin
        slot_used[i]  <= 1'b0;
        slot_st[i]    <= ST_ASSOC;
        slot_miss[i]  <= '0;
        ring_head[i]  <= '0;
        ring_fill[i]  <= '0;
        free_stack[i] <= SW'(i);
      end
    end else begin
      state <= state_next;
      if (cfg_valid) maxex <= cfg_data;

      case (state)
        S_IDLE: begin
          func_r  <= in_func;
          id_r    <= in_id;
          oid_r   <= in_oid;
          pt_r    <= in_pt;
          assoc_r <= in_assoc;
          sc      <= '0;
          s_hit   <= 1'b0;
          t_hit   <= 1'b0;
        end
        S_SCAN: begin
          // lowest used slot holding the id wins
          if (!s_hit && slot_used[sc] && slot_tid[sc] == id_r) begin
            s_hit <= 1'b1;
            s_idx <= sc;
          end
          if (!t_hit && slot_used[sc] && slot_tid[sc] == oid_r) begin
            t_hit <= 1'b1;
            t_idx <= sc;
          end
          sc <= SW'(sc + 1'b1);
        end
        S_EXEC: begin
          res_r <= exec_res;
          case (func_r)
            FN_CREATE: begin
              if (free_depth != '0) begin
                slot_used[free_stack[SW'(free_depth - 1'b1)]] <= 1'b1;
                slot_tid[free_stack[SW'(free_depth - 1'b1)]]  <= next_id;
                slot_st[free_stack[SW'(free_depth - 1'b1)]]   <= ST_ASSOC;
                slot_miss[free_stack[SW'(free_depth - 1'b1)]] <= '0;
                ring_head[free_stack[SW'(free_depth - 1'b1)]] <= '0;
                ring_fill[free_stack[SW'(free_depth - 1'b1)]] <= '0;
                free_depth <= DW'(free_depth - 1'b1);
                next_id    <= (next_id == '1) ? IW'(1) : IW'(next_id + 1'b1);
              end
            end
            FN_DELETE, FN_PUSH: begin
              if (s_hit) begin
                if (func_r == FN_DELETE || ss == ST_TERM) begin
                  slot_used[s_idx] <= 1'b0;
                  slot_st[s_idx]   <= ST_ASSOC;
                  slot_miss[s_idx] <= '0;
                  ring_head[s_idx] <= '0;
                  ring_fill[s_idx] <= '0;
                  if (free_depth < DW'(TRACKS)) begin
                    free_stack[SW'(free_depth)] <= s_idx;
                    free_depth <= DW'(free_depth + 1'b1);
                  end
                end else begin
                  ring_head[s_idx] <= ptr_inc(hs);
                  ring_fill[s_idx] <= push_fill;
                  slot_st[s_idx]   <= push_st;
                  slot_miss[s_idx] <= push_miss;
                end
              end
            end
            FN_MERGE: begin
              cnt      <= FW'(maxex);
              sptr     <= hs;
              tptr     <= ring_head[t_idx];
            end
            FN_READ: begin
              cnt  <= '0;
              sptr <= rd_start;
            end
            FN_CLEAR: begin
              free_depth <= DW'(TRACKS);
              next_id    <= IW'(1);
              for (int i = 0; i < TRACKS; i++) begin
                slot_used[i]  <= 1'b0;
                slot_st[i]    <= ST_ASSOC;
                slot_miss[i]  <= '0;
                ring_head[i]  <= '0;
                ring_fill[i]  <= '0;
                free_stack[i] <= SW'(i);
              end
            end
            default: begin
              cnt <= cnt;
            end
          endcase
        end
        S_MRG_RD: begin
          // walk both rings backwards from the newest point
          sptr <= ptr_dec(sptr);
          tptr <= ptr_dec(tptr);
        end
        S_MRG_WR: begin
          cnt <= FW'(cnt - 1'b1);
        end
        S_MRG_END: begin
          slot_tid[t_idx]  <= slot_tid[s_idx];
          slot_st[t_idx]   <= ss;
          slot_miss[t_idx] <= ms;
          slot_used[s_idx] <= 1'b0;
          slot_st[s_idx]   <= ST_ASSOC;
          slot_miss[s_idx] <= '0;
          ring_head[s_idx] <= '0;
          ring_fill[s_idx] <= '0;
          if (free_depth < DW'(TRACKS)) begin
            free_stack[SW'(free_depth)] <= s_idx;
            free_depth <= DW'(free_depth + 1'b1);
          end
          res_r.ok   <= 1'b1;
          res_r.st   <= ss;
          res_r.miss <= ms;
          res_r.cnt  <= 5'(ft);
        end
        S_RD_DATA: begin
          res_r.ok   <= 1'b1;
          res_r.id   <= 16'(id_r);
          res_r.st   <= ss;
          res_r.miss <= ms;
          res_r.cnt  <= 5'(fs);
          res_r.pt   <= 64'(ram_rdata);
          res_r.pv   <= 1'b1;
          res_r.last <= (FW'(cnt + 1'b1) == fs);
          sptr       <= ptr_inc(sptr);
          cnt        <= FW'(cnt + 1'b1);
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

endmodule

/* src/ttab_ram.sv */
// ----------------------------------------------------------------------------
// ttab_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ttab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ttab_checker.sv */
// ----------------------------------------------------------------------------
// ttab_checker
// port level checks of the track table engine, bound to the top level
// ----------------------------------------------------------------------------
module ttab_checker
  import ttab_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while busy");

  // no command taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("ready with result pending");

  // a stored point is only shown on success
  a_pv_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("point without ok");

  // no point, no point payload
  a_pt_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[89:26] == '0)
    else $error("point payload without point");

endmodule

bind track_table_engine ttab_checker u_ttab_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
